### rtl/mbls_pkg.sv
// shared constants, types and codes for the bounded list store
package mbls_pkg;

    localparam int NUM_SLOTS  = 10;
    localparam int MAX_CAP    = 16;
    localparam int DATA_WIDTH = 32;

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int POS_W   = $clog2(MAX_CAP);
    localparam int CNT_W   = $clog2(MAX_CAP + 1);
    localparam int ADDR_W  = $clog2(NUM_SLOTS * MAX_CAP);
    localparam int DEPTH   = NUM_SLOTS * MAX_CAP;

    // request codes
    localparam logic [2:0] REQ_CREATE  = 3'd0;
    localparam logic [2:0] REQ_APPEND  = 3'd1;
    localparam logic [2:0] REQ_POP     = 3'd2;
    localparam logic [2:0] REQ_REMOVE  = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;
    localparam logic [2:0] REQ_RESIZE  = 3'd5;

    // status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_SLOT  = 4'd1;
    localparam logic [3:0] ST_EXISTS    = 4'd2;
    localparam logic [3:0] ST_BAD_SIZE  = 4'd3;
    localparam logic [3:0] ST_NO_MEM    = 4'd4;
    localparam logic [3:0] ST_FULL      = 4'd5;
    localparam logic [3:0] ST_NO_SLOT   = 4'd6;
    localparam logic [3:0] ST_EMPTY     = 4'd7;
    localparam logic [3:0] ST_NOT_FOUND = 4'd8;
    localparam logic [3:0] ST_BAD_NEW   = 4'd9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_READ,
        S_OUT
    } state_t;

    // element memory port
    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [DATA_WIDTH-1:0] wr_data;
        logic [ADDR_W-1:0]     rd_addr;
    } mem_req_t;

    // slot number and position to memory address
    function automatic logic [ADDR_W-1:0] elem_addr(input logic [SLOT_W-1:0] s,
                                                    input logic [POS_W:0] p);
        logic [ADDR_W+POS_W:0] a;
        begin
            a = ADDR_W'(s) * (ADDR_W+POS_W+1)'(MAX_CAP) + (ADDR_W+POS_W+1)'(p);
            return a[ADDR_W-1:0];
        end
    endfunction

endpackage

### rtl/mbls_elem_ram.sv
// element store: one write port, one registered read port
module mbls_elem_ram
    import mbls_pkg::*;
(
    input  logic                  clk,
    input  mem_req_t              req,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rd_data <= mem[req.rd_addr];
    end

endmodule

### rtl/mbls_ctrl.sv
// request sequencer: slot table, search, shift and read-out
module mbls_ctrl
    import mbls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            req_type,
    input  logic [3:0]            slot,
    input  logic [31:0]           value,
    input  logic [7:0]            size_arg,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            status,
    output logic [31:0]           data,
    output logic                  data_valid,
    output logic [4:0]            count,
    output logic                  last,
    output mem_req_t              mem_req,
    input  logic [DATA_WIDTH-1:0] mem_rd_data
);

    state_t state_reg, state_next;

    // slot table
    logic [NUM_SLOTS-1:0] exists_reg;
    logic [CNT_W-1:0]     cap_reg [NUM_SLOTS];
    logic [CNT_W-1:0]     cnt_reg [NUM_SLOTS];

    // request being worked on
    logic [SLOT_W-1:0]     s_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [POS_W:0]        idx_reg, idx_next;

    // output register
    logic                  ov_reg;
    logic [3:0]            st_reg;
    logic [31:0]           dat_reg;
    logic                  dv_reg;
    logic [4:0]            oc_reg;
    logic                  last_reg;

    logic                  out_free;
    logic                  acc;
    logic [SLOT_W-1:0]     in_s;
    logic                  pos_ok;
    logic [CNT_W-1:0]      c_in, k_in;
    logic signed [9:0]     ncap;
    logic signed [8:0]     sz;
    logic [DATA_WIDTH-1:0] in_word;
    logic                  rd_pend_reg;

    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign acc      = in_valid && in_ready;
    assign pos_ok   = (slot >= 4'd1) && (slot <= 4'(NUM_SLOTS));
    assign in_s     = SLOT_W'(slot - 4'd1);
    assign c_in     = cnt_reg[in_s];
    assign k_in     = cap_reg[in_s];
    assign sz       = 9'($signed(size_arg));
    assign ncap     = 10'($signed({1'b0, k_in})) + 10'(sz);
    assign in_word  = DATA_WIDTH'(value);

    assign out_valid  = ov_reg;
    assign status     = st_reg;
    assign data       = dat_reg;
    assign data_valid = dv_reg;
    assign count      = oc_reg;
    assign last       = last_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and memory addressing
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = elem_addr(s_reg, idx_reg);
        mem_req.wr_data = mem_rd_data;
        mem_req.rd_addr = elem_addr(s_reg, idx_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                mem_req.rd_addr = elem_addr(in_s, '0);
                mem_req.wr_addr = elem_addr(in_s, (POS_W+1)'(c_in));
                mem_req.wr_data = in_word;
                idx_next        = '0;
                if (acc && pos_ok && exists_reg[in_s])
                begin
                    priority if (req_type == REQ_APPEND)
                    begin
                        mem_req.wr_en = (c_in < k_in) && (c_in < CNT_W'(MAX_CAP));
                    end
                    else if (req_type == REQ_REMOVE && c_in != '0)
                    begin
                        state_next = S_SEARCH;
                    end
                    else if (req_type == REQ_READ && c_in != '0)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            // one entry compared per cycle while the output register is free, read issued for idx+1
            S_SEARCH:
            begin
                mem_req.rd_addr = elem_addr(s_reg, idx_reg + 1'b1);
                if (out_free)
                begin
                    if (mem_rd_data == val_reg)
                    begin
                        state_next = S_SHIFT;
                    end
                    else if (idx_reg + 1'b1 == (POS_W+1)'(n_reg))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    mem_req.rd_addr = elem_addr(s_reg, idx_reg);
                end
            end
            // entry idx+1 now on read data: copy down to idx
            S_SHIFT:
            begin
                if (idx_reg + 1'b1 >= (POS_W+1)'(n_reg))
                begin
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.rd_addr = elem_addr(s_reg, idx_reg + 2'd2);
                    idx_next        = idx_reg + 1'b1;
                end
            end
            // read-out: present entry idx when its read data is valid and the output register is free
            S_READ:
            begin
                if (out_free && rd_pend_reg)
                begin
                    idx_next        = idx_reg + 1'b1;
                    mem_req.rd_addr = elem_addr(s_reg, idx_reg + 1'b1);
                    if (idx_reg + 1'b1 == (POS_W+1)'(n_reg))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // index register; the shift pass picks up the read of idx+1 that was issued in search
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    // read data valid flag: set once a read address has been held in read-out, cleared when an entry is presented
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == S_READ) && !(out_free && rd_pend_reg);
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s_reg   <= in_s;
            val_reg <= in_word;
            n_reg   <= c_in;
        end
    end

    // slot table and output register updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exists_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                cap_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            ov_reg   <= 1'b0;
            st_reg   <= ST_OK;
            dat_reg  <= '0;
            dv_reg   <= 1'b0;
            oc_reg   <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc && req_type <= REQ_RESIZE)
                    begin
                        ov_reg   <= 1'b1;
                        dat_reg  <= '0;
                        dv_reg   <= 1'b0;
                        last_reg <= 1'b1;
                        st_reg   <= ST_OK;
                        oc_reg   <= 5'(c_in);
                        if (!pos_ok)
                        begin
                            st_reg <= ST_BAD_SLOT;
                            oc_reg <= '0;
                        end
                        else if (req_type == REQ_CREATE)
                        begin
                            priority if (exists_reg[in_s])
                                st_reg <= ST_EXISTS;
                            else if (sz < 9'sd1)
                                st_reg <= ST_BAD_SIZE;
                            else if (sz > 9'(MAX_CAP))
                                st_reg <= ST_NO_MEM;
                            else
                            begin
                                exists_reg[in_s] <= 1'b1;
                                cap_reg[in_s]    <= CNT_W'(sz);
                                cnt_reg[in_s]    <= '0;
                                oc_reg           <= '0;
                            end
                        end
                        else if (!exists_reg[in_s])
                        begin
                            st_reg <= ST_NO_SLOT;
                        end
                        else
                        begin
                            unique case (req_type)
                                REQ_APPEND:
                                begin
                                    if ((c_in < k_in) && (c_in < CNT_W'(MAX_CAP)))
                                    begin
                                        cnt_reg[in_s] <= c_in + 1'b1;
                                        oc_reg        <= 5'(c_in + 1'b1);
                                    end
                                    else
                                    begin
                                        st_reg <= ST_FULL;
                                    end
                                end
                                REQ_POP:
                                begin
                                    if (c_in == '0)
                                    begin
                                        st_reg <= ST_EMPTY;
                                    end
                                    else
                                    begin
                                        cnt_reg[in_s] <= c_in - 1'b1;
                                        oc_reg        <= 5'(c_in - 1'b1);
                                    end
                                end
                                REQ_REMOVE, REQ_READ:
                                begin
                                    if (c_in == '0)
                                    begin
                                        st_reg <= (req_type == REQ_REMOVE) ? ST_EMPTY : ST_OK;
                                    end
                                    else
                                    begin
                                        ov_reg <= 1'b0;
                                    end
                                end
                                default:
                                begin
                                    priority if (ncap < 10'sd1)
                                        st_reg <= ST_BAD_NEW;
                                    else if (ncap > 10'(MAX_CAP))
                                        st_reg <= ST_NO_MEM;
                                    else
                                    begin
                                        cap_reg[in_s] <= CNT_W'(ncap);
                                        if (10'($signed({1'b0, c_in})) > ncap)
                                        begin
                                            cnt_reg[in_s] <= CNT_W'(ncap);
                                            oc_reg        <= 5'(ncap);
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (out_free && mem_rd_data != val_reg
                        && idx_reg + 1'b1 == (POS_W+1)'(n_reg))
                    begin
                        ov_reg   <= 1'b1;
                        st_reg   <= ST_NOT_FOUND;
                        dat_reg  <= '0;
                        dv_reg   <= 1'b0;
                        oc_reg   <= 5'(n_reg);
                        last_reg <= 1'b1;
                    end
                end
                S_SHIFT:
                begin
                    if (idx_reg + 1'b1 >= (POS_W+1)'(n_reg) && out_free)
                    begin
                        cnt_reg[s_reg] <= n_reg - 1'b1;
                        ov_reg   <= 1'b1;
                        st_reg   <= ST_OK;
                        dat_reg  <= '0;
                        dv_reg   <= 1'b0;
                        oc_reg   <= 5'(n_reg - 1'b1);
                        last_reg <= 1'b1;
                    end
                end
                S_READ:
                begin
                    if (out_free && rd_pend_reg)
                    begin
                        ov_reg   <= 1'b1;
                        st_reg   <= ST_OK;
                        dat_reg  <= 32'(mem_rd_data);
                        dv_reg   <= 1'b1;
                        oc_reg   <= 5'(n_reg);
                        last_reg <= (idx_reg + 1'b1 == (POS_W+1)'(n_reg));
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

### rtl/multi_bank_bounded_list_store_top.sv
// Bounded list store top level: NUM_SLOTS slots of up to MAX_CAP words each.
// Create, append, remove last and resize each give one result.
// Remove-by-value scans the slot one memory read per cycle, then shifts the
// later entries down one per cycle. Read out gives one result per element:
// each read address is held until its registered data is valid, and only
// then is the result loaded. Results sit in a single output register, and
// the input is held off while a result waits there, so a stalled receiver
// stalls the whole block.
module multi_bank_bounded_list_store_top
    import mbls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [3:0]  slot,
    input  logic [31:0] value,
    input  logic [7:0]  size_arg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [31:0] data,
    output logic        data_valid,
    output logic [4:0]  count,
    output logic        last
);

    mem_req_t              mem_req;
    logic [DATA_WIDTH-1:0] mem_rd_data;

    // sequencer
    mbls_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .slot        (slot),
        .value       (value),
        .size_arg    (size_arg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .data        (data),
        .data_valid  (data_valid),
        .count       (count),
        .last        (last),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    // element memory
    mbls_elem_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

endmodule

### rtl/mbls_checker.sv
// port-level checks for the bounded list store
module mbls_port_checks
    import mbls_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  status,
    input logic        data_valid,
    input logic [4:0]  count
);

    // a request that waits stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("request withdrawn while waiting");

    // a result that waits keeps its content
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count))
        else $error("result changed while stalled");

    // element data only comes with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_valid |-> status == ST_OK)
        else $error("data valid with error status");

    // bad slot reports zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_BAD_SLOT |-> count == 5'd0)
        else $error("bad slot with count");

    // status stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_BAD_NEW)
        else $error("status out of range");

endmodule

bind multi_bank_bounded_list_store_top mbls_port_checks u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .data_valid (data_valid),
    .count      (count)
);
